### hw/rtl/vafr_pkg.sv
// ----------------------------------------------------------------------------
// Fade ramp package
// Shared constants, command codes and helpers for the fade ramp generator.
// ----------------------------------------------------------------------------
package vafr_pkg;

  localparam int FULL_LEVEL    = 256;
  localparam int OFFSET_FLOOR  = 255;
  localparam int VOLUME_MAX    = 15;

  localparam int LEVEL_W       = 9;
  localparam int VALUE_W       = 10;
  localparam int FRAMES_W      = 10;
  localparam int OFFSET_W      = 9;
  localparam int VOLUME_W      = 4;

  localparam int DIFF_W        = 22;
  localparam int PROD_W        = 21;
  localparam int DIV_BITS      = 20;
  localparam int DIV_CNT_W     = 5;

  localparam int IN_DATA_W     = 24;
  localparam int IN_USER_W     = 2;
  localparam int OUT_DATA_W    = 24;

  localparam logic [1:0] CMD_SET  = 2'd0;
  localparam logic [1:0] CMD_RAMP = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MUL    = 5'b00010,
    ST_DSTART = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_FIN    = 5'b10000
  } state_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic signed [DIFF_W-1:0] lvl);
    logic [LEVEL_W-1:0] res;
    if (lvl < 0) begin
      res = '0;
    end else if (lvl > DIFF_W'(FULL_LEVEL)) begin
      res = LEVEL_W'(FULL_LEVEL);
    end else begin
      res = lvl[LEVEL_W-1:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/vafr_div.sv
// ----------------------------------------------------------------------------
// Fade ramp divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vafr_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [vafr_pkg::DIV_BITS-1:0]     dividend,
  input  logic [vafr_pkg::FRAMES_W-1:0]     divisor,
  output logic                              done,
  output logic [vafr_pkg::DIV_BITS-1:0]     quotient
);
  import vafr_pkg::*;

  logic [DIV_BITS-1:0]  acc_r, acc_nxt;
  logic [FRAMES_W-1:0]  rem_r, rem_nxt;
  logic [FRAMES_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [FRAMES_W:0]    rem_sh;
  logic                 ge;

  assign rem_sh = {rem_r, acc_r[DIV_BITS-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? FRAMES_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[FRAMES_W-1:0];
      acc_nxt = {acc_r[DIV_BITS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = acc_r;

endmodule

### hw/rtl/video_audio_fade_ramp.sv
// ----------------------------------------------------------------------------
// Video and audio fade ramp generator
// Holds a brightness level and ramps it linearly over frame ticks.
// ----------------------------------------------------------------------------
// A set or ramp command goes from transfer straight to the result stage, and so
// does a tick while no ramp runs. A tick during a ramp first multiplies the
// level difference by the step count, then runs a bit-serial divide by the
// ramp length, then the clamp and the result. Input is taken again as soon as
// the previous result sits in the output register.
// ----------------------------------------------------------------------------
module video_audio_fade_ramp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // level_value [9:0], frame_count [19:10], zero fill [23:20]
  input  logic [vafr_pkg::IN_DATA_W-1:0]      in_tdata,
  // command [1:0]
  input  logic [vafr_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // current_level [8:0], colour_offset [17:9], master_volume [21:18],
  // ramp_busy [22], zero fill [23]
  output logic [vafr_pkg::OUT_DATA_W-1:0]     out_tdata
);
  import vafr_pkg::*;

  state_t                      state_r, state_nxt;
  logic [LEVEL_W-1:0]          level_r, level_nxt;
  logic [LEVEL_W-1:0]          start_r, start_nxt;
  logic signed [VALUE_W-1:0]   target_r, target_nxt;
  logic [FRAMES_W-1:0]         length_r, length_nxt;
  logic [FRAMES_W-1:0]         step_r, step_nxt;
  logic                        running_r, running_nxt;
  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]       out_data_r, out_data_nxt;

  logic [1:0]                  cmd;
  logic signed [VALUE_W-1:0]   value;
  logic [FRAMES_W-1:0]         frames;
  logic                        accept;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [DIFF_W-1:0]    step_s;
  logic                        prod_neg;
  logic [DIV_BITS-1:0]         mag;
  logic                        div_start;
  logic                        div_done;
  logic [DIV_BITS-1:0]         quo;
  logic signed [DIFF_W-1:0]    quo_s;
  logic signed [DIFF_W-1:0]    ramp_lvl;
  logic [16:0]                 off_prod;
  logic [LEVEL_W-1:0]          off_mag;
  logic [OFFSET_W-1:0]         offset;
  logic [12:0]                 vol_prod;
  logic [VOLUME_W-1:0]         volume;

  assign cmd    = in_tuser;
  assign value  = $signed(in_tdata[VALUE_W-1:0]);
  assign frames = in_tdata[VALUE_W+FRAMES_W-1:VALUE_W];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  assign diff   = DIFF_W'(target_r) - $signed({{(DIFF_W-LEVEL_W){1'b0}}, start_r});
  assign step_s = $signed({{(DIFF_W-FRAMES_W){1'b0}}, step_r});

  assign prod_neg  = prod_r[PROD_W-1];
  assign mag       = prod_neg ? DIV_BITS'(-prod_r) : DIV_BITS'(prod_r);
  assign div_start = (state_r == ST_DSTART);

  vafr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (mag),
    .divisor  (length_r),
    .done     (div_done),
    .quotient (quo)
  );

  assign quo_s    = prod_neg ? -$signed({{(DIFF_W-DIV_BITS){1'b0}}, quo})
                             :  $signed({{(DIFF_W-DIV_BITS){1'b0}}, quo});
  assign ramp_lvl = $signed({{(DIFF_W-LEVEL_W){1'b0}}, start_r}) + quo_s;

  assign off_prod = 17'(OFFSET_FLOOR) * 17'(LEVEL_W'(FULL_LEVEL) - level_r);
  assign off_mag  = LEVEL_W'(off_prod / 17'(FULL_LEVEL));
  assign offset   = OFFSET_W'(-off_mag);
  assign vol_prod = 13'(VOLUME_MAX) * 13'(level_r);
  assign volume   = VOLUME_W'(vol_prod / 13'(FULL_LEVEL));

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    start_nxt     = start_r;
    target_nxt    = target_r;
    length_nxt    = length_r;
    step_nxt      = step_r;
    running_nxt   = running_r;
    prod_nxt      = prod_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_FIN;
          unique case (cmd)
            CMD_SET: begin
              running_nxt = 1'b0;
              level_nxt   = clamp_level(DIFF_W'(value));
            end
            CMD_RAMP: begin
              if (frames == '0) begin
                running_nxt = 1'b0;
                level_nxt   = clamp_level(DIFF_W'(value));
              end else begin
                start_nxt   = level_r;
                target_nxt  = value;
                length_nxt  = frames;
                step_nxt    = '0;
                running_nxt = 1'b1;
              end
            end
            CMD_TICK: begin
              if (running_r) begin
                step_nxt  = step_r + 1'b1;
                state_nxt = ST_MUL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(diff * step_s);
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          level_nxt = clamp_level(ramp_lvl);
          if (step_r >= length_r) begin
            running_nxt = 1'b0;
          end
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0, running_r, volume, offset, level_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      level_r     <= LEVEL_W'(FULL_LEVEL);
      start_r     <= '0;
      target_r    <= '0;
      length_r    <= '0;
      step_r      <= '0;
      running_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      level_r     <= level_nxt;
      start_r     <= start_nxt;
      target_r    <= target_nxt;
      length_r    <= length_nxt;
      step_r      <= step_nxt;
      running_r   <= running_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r     <= prod_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

### tb/sv/fade_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fade ramp checker
// Watches the command and result streams of the fade ramp generator, keeps
// its own copy of the level and ramp state, predicts the result of every
// accepted command and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module fade_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [vafr_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [vafr_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [vafr_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              fail_count,
  output int                              pending
);

  typedef struct packed {
    logic                busy;
    logic [3:0]          volume;
    logic signed [8:0]   offset;
    logic [8:0]          level;
  } fade_result_t;

  logic [8:0]        level_now;
  logic [8:0]        ramp_from;
  logic signed [9:0] ramp_to;
  logic [9:0]        ramp_len;
  logic [9:0]        ramp_pos;
  logic              ramp_on;

  fade_result_t expected_q[$];
  fade_result_t want;
  fade_result_t seen;

  function automatic logic [8:0] limit_level(input int lvl);
    if (lvl < 0) begin
      return 9'd0;
    end
    if (lvl > vafr_pkg::FULL_LEVEL) begin
      return 9'(vafr_pkg::FULL_LEVEL);
    end
    return 9'(lvl);
  endfunction

  task automatic advance_fade(input logic [1:0] cmd, input logic signed [9:0] value,
                              input logic [9:0] frames, output fade_result_t res);
    int span;
    int lvl;
    case (cmd)
      vafr_pkg::CMD_SET: begin
        ramp_on   = 1'b0;
        level_now = limit_level(int'(value));
      end
      vafr_pkg::CMD_RAMP: begin
        if (frames == 10'd0) begin
          ramp_on   = 1'b0;
          level_now = limit_level(int'(value));
        end else begin
          ramp_from = level_now;
          ramp_to   = value;
          ramp_len  = frames;
          ramp_pos  = 10'd0;
          ramp_on   = 1'b1;
        end
      end
      vafr_pkg::CMD_TICK: begin
        if (ramp_on && ramp_len != 10'd0) begin
          ramp_pos  = ramp_pos + 10'd1;
          span      = (int'(ramp_to) - int'(ramp_from)) * int'(ramp_pos);
          level_now = limit_level(int'(ramp_from) + span / int'(ramp_len));
          if (ramp_pos >= ramp_len) begin
            ramp_on = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
    lvl        = int'(level_now);
    res.level  = level_now;
    res.offset = 9'(-((vafr_pkg::OFFSET_FLOOR * (vafr_pkg::FULL_LEVEL - lvl))
                      / vafr_pkg::FULL_LEVEL));
    res.volume = 4'((lvl * vafr_pkg::VOLUME_MAX) / vafr_pkg::FULL_LEVEL);
    res.busy   = ramp_on;
  endtask

  task automatic report_mismatch(input string what, input int want_val, input int seen_val);
    $display("%0t: mismatch in %s: expected %0d, got %0d", $time, what, want_val, seen_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      level_now = 9'(vafr_pkg::FULL_LEVEL);
      ramp_from = '0;
      ramp_to   = '0;
      ramp_len  = '0;
      ramp_pos  = '0;
      ramp_on   = 1'b0;
      expected_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        advance_fade(in_tuser, in_tdata[9:0], in_tdata[19:10], want);
        expected_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        seen.level  = out_tdata[8:0];
        seen.offset = out_tdata[17:9];
        seen.volume = out_tdata[21:18];
        seen.busy   = out_tdata[22];
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result level", -1, int'(seen.level));
        end else begin
          want = expected_q.pop_front();
          if (seen.level !== want.level) begin
            report_mismatch("current_level", int'(want.level), int'(seen.level));
          end
          if (seen.offset !== want.offset) begin
            report_mismatch("colour_offset", int'(want.offset), int'(seen.offset));
          end
          if (seen.volume !== want.volume) begin
            report_mismatch("master_volume", int'(want.volume), int'(seen.volume));
          end
          if (seen.busy !== want.busy) begin
            report_mismatch("ramp_busy", int'(want.busy), int'(seen.busy));
          end
          if (out_tdata[23] !== 1'b0) begin
            report_mismatch("zero fill", 0, int'(out_tdata[23]));
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fade ramp generator testbench
// Drives set, ramp and tick commands into the fade ramp generator: a directed
// run over the edge cases, then random ramps with ticks, sets and noise, with
// random gaps on the command side and stalls on the result side.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 1000;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [vafr_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [vafr_pkg::IN_USER_W-1:0]  in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [vafr_pkg::OUT_DATA_W-1:0] out_tdata;

  int fail_count;
  int pending;
  int cycle_count;
  int items_sent;
  int gap_pct;
  int stall_pct;

  video_audio_fade_ramp u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  fade_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_cmd(input logic [1:0] cmd, input int value, input int frames);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {4'b0000, 10'(frames), 10'(value)};
    do @(posedge clk); while (!in_tready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_cmd(vafr_pkg::CMD_TICK, int'($urandom_range(0, 1023)),
                            int'($urandom_range(0, 1023)));
  endtask

  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic int pick_level();
    if ($urandom_range(0, 1) == 0) begin
      return int'($urandom_range(0, 256));
    end
    return int'($urandom_range(0, 1023)) - 512;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 40;
    endcase
  endfunction

  initial begin
    int frames;
    int ticks;
    int cut;
    int next_mix;
    bit long_done;
    bit pressure_done;

    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = vafr_pkg::CMD_SET;
    items_sent = 0;
    gap_pct    = 30;
    stall_pct  = 30;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: clamps, ramp edge cases and the unused command code.
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);
    send_cmd(vafr_pkg::CMD_SET, 256, 0);
    send_cmd(vafr_pkg::CMD_SET, 0, 1023);
    send_cmd(vafr_pkg::CMD_SET, -512, 0);
    send_cmd(vafr_pkg::CMD_SET, 511, 0);
    send_cmd(vafr_pkg::CMD_SET, 128, 0);
    send_cmd(vafr_pkg::CMD_RAMP, 200, 0);
    send_cmd(vafr_pkg::CMD_RAMP, 0, 4);
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);
    send_cmd(vafr_pkg::CMD_RAMP, 511, 3);
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);
    send_cmd(vafr_pkg::CMD_SET, 64, 0);
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);
    send_cmd(vafr_pkg::CMD_RAMP, -512, 2);
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);
    send_cmd(CMD_UNUSED, 511, 1023);
    send_cmd(vafr_pkg::CMD_RAMP, 100, 1023);
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);
    send_cmd(vafr_pkg::CMD_SET, 10, 0);
    send_cmd(vafr_pkg::CMD_RAMP, 256, 1);
    send_cmd(vafr_pkg::CMD_TICK, 0, 0);

    // The sender holds off here until the block has answered everything.
    wait_all_results();

    long_done     = 1'b0;
    pressure_done = 1'b0;
    next_mix      = items_sent;
    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= ITEM_TARGET - 150) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else if (items_sent >= next_mix) begin
        gap_pct   = pick_pct();
        stall_pct = pick_pct();
        next_mix  = items_sent + 50;
      end
      if (!pressure_done && items_sent >= ITEM_TARGET / 2) begin
        wait_all_results();
        pressure_done = 1'b1;
      end
      if (!long_done && items_sent >= ITEM_TARGET / 3) begin
        frames = int'($urandom_range(200, 300));
        send_cmd(vafr_pkg::CMD_RAMP, pick_level(), frames);
        send_ticks(frames + 1);
        long_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          frames = ($urandom_range(0, 9) == 0) ? 0 : int'($urandom_range(1, 12));
          ticks  = frames + int'($urandom_range(0, 2));
          send_cmd(vafr_pkg::CMD_RAMP, pick_level(), frames);
          if ($urandom_range(0, 9) == 0 && ticks > 1) begin
            cut = int'($urandom_range(1, ticks - 1));
            send_ticks(cut);
            send_cmd($urandom_range(0, 1) ? vafr_pkg::CMD_SET : vafr_pkg::CMD_RAMP,
                     pick_level(), int'($urandom_range(1, 12)));
            send_ticks(ticks - cut);
          end else begin
            send_ticks(ticks);
          end
        end
        6, 7: begin
          send_cmd(vafr_pkg::CMD_SET, pick_level(), int'($urandom_range(0, 1023)));
        end
        default: begin
          send_cmd(2'($urandom_range(0, 3)), int'($urandom_range(0, 1023)),
                   ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 1023))
                                               : int'($urandom_range(0, 15)));
        end
      endcase
    end

    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
